### hdl/csched_pkg.sv
// ---------------------------------------------------------------------------
// csched_pkg
// Shared types and constants for the cooperative task scheduler: command and
// result codes, the slot record, the sequencer states and the slot unit result.
// ---------------------------------------------------------------------------
package csched_pkg;

	// default table depth
	localparam int unsigned MaxTasksDefault = 16;

	// field widths fixed by the stream format
	localparam int unsigned HandleW  = 16;
	localparam int unsigned DelayW   = 32;
	localparam int unsigned PendingW = 8;
	localparam int unsigned SlotW    = 4;

	// command codes carried on the input tuser
	typedef enum logic [1:0] {
		CMD_TICK     = 2'd0,
		CMD_ADD      = 2'd1,
		CMD_DISPATCH = 2'd2,
		CMD_CLEAR    = 2'd3
	} cmd_t;

	// result kinds carried on the output tuser
	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_RUN = 2'd1,
		KIND_END = 2'd2
	} kind_t;

	// one task slot as held in the table
	typedef struct packed {
		logic [HandleW-1:0]  handle;
		logic [DelayW-1:0]   delay;
		logic [DelayW-1:0]   period;
		logic [PendingW-1:0] pending;
	} slot_t;

	// what the slot unit decides for the slot under the walk
	typedef struct packed {
		logic  wr_en;
		logic  emit;
		slot_t nxt;
	} slot_upd_t;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_WALK = 4'b0100,
		ST_END  = 4'b1000
	} state_t;

endpackage

### hdl/csched_slot_unit.sv
// ---------------------------------------------------------------------------
// csched_slot_unit
// Shared update unit used once per slot during a tick or dispatch walk:
// delay countdown and reload, pending count update and one-shot release.
// ---------------------------------------------------------------------------
module csched_slot_unit
	import csched_pkg::*;
(
	input  logic      is_dispatch,
	input  slot_t     cur,
	output slot_upd_t upd
);

	logic delay_zero;
	logic period_zero;
	logic pending_zero;
	logic pending_full;

	assign delay_zero   = (cur.delay == '0);
	assign period_zero  = (cur.period == '0);
	assign pending_zero = (cur.pending == '0);
	assign pending_full = (cur.pending == '1);

	// per-slot update for the current walk
	always_comb begin
		upd     = '0;
		upd.nxt = cur;
		if (is_dispatch) begin
			upd.wr_en = !pending_zero;
			upd.emit  = !pending_zero;
			if (period_zero) begin
				// one-shot task leaves the table after its run
				upd.nxt = '0;
			end else begin
				upd.nxt.pending = cur.pending - PendingW'(1);
			end
		end else begin
			// empty handle slots are never ticked
			upd.wr_en = (cur.handle != '0);
			if (delay_zero) begin
				if (!pending_full) begin
					upd.nxt.pending = cur.pending + PendingW'(1);
				end
				if (!period_zero) begin
					upd.nxt.delay = cur.period;
				end
			end else begin
				upd.nxt.delay = cur.delay - DelayW'(1);
			end
		end
	end

endmodule

### hdl/cooperative_task_scheduler.sv
// ---------------------------------------------------------------------------
// cooperative_task_scheduler
// Time-triggered cooperative scheduler over a fixed table of task slots.
//
// Input stream: s_tuser carries the command (tick, add, dispatch, clear),
// s_tdata the add arguments. Output stream: m_tuser carries the result kind,
// m_tdata the add flag, slot and handle, m_tlast marks the final result of
// a command.
// Clear returns nothing; add returns one response. Tick and dispatch walk the
// used slots one per cycle, while the output is not stalled, through the
// shared slot unit and table read port; a dispatch then adds one closing
// result. One command is worked at a time; s_tready is low while it runs.
// A finished result waits in the output register; while the receiver stalls
// the walk halts on the slot that wants to emit and resumes when taken.
// Reset empties the table (used count zero) and drops any pending result;
// slot contents need no clearing since only added slots are ever read.
// ---------------------------------------------------------------------------
module cooperative_task_scheduler
	import csched_pkg::*;
#(
	parameter int unsigned MAX_TASKS = MaxTasksDefault
)(
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // task_handle[15:0], first_delay[47:16], repeat_period[79:48]
	input  logic [1:0]  s_tuser,   // cmd[1:0]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // accepted[0], slot[4:1], run_handle[20:5], zero[23:21]
	output logic [1:0]  m_tuser,   // kind[1:0]
	output logic        m_tlast
);

	localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int unsigned CW = $clog2(MAX_TASKS + 1);

	state_t             state_q;
	cmd_t               cmd_q;
	slot_t              new_slot_q;
	logic [CW-1:0]      used_q;
	logic [CW-1:0]      walk_q;
	logic [CW-1:0]      walk_inc;
	slot_t              slot_mem_q [MAX_TASKS];
	slot_t              rd_slot_q;

	logic               out_valid_q;
	kind_t              out_kind_q;
	logic               out_acc_q;
	logic [SlotW-1:0]   out_slot_q;
	logic [HandleW-1:0] out_handle_q;
	logic               out_last_q;

	logic               in_xact;
	logic               out_free;
	logic               table_full;
	logic               walk_adv;
	logic               walk_done;
	slot_upd_t          upd;

	logic               mem_we;
	logic [IW-1:0]      mem_waddr;
	slot_t              mem_wdata;
	logic [IW-1:0]      mem_raddr;

	logic               out_load;
	kind_t              out_kind_d;
	logic               out_acc_d;
	logic [SlotW-1:0]   out_slot_d;
	logic [HandleW-1:0] out_handle_d;
	logic               out_last_d;
	logic [IW+SlotW-1:0] used_ext;
	logic [IW+SlotW-1:0] walk_ext;

	assign s_tready   = (state_q == ST_IDLE);
	assign in_xact    = s_tvalid && s_tready;
	assign out_free   = !out_valid_q || m_tready;
	assign table_full = (used_q >= CW'(MAX_TASKS));
	assign walk_inc   = walk_q + CW'(1);
	assign walk_done  = (walk_inc == used_q);
	assign used_ext   = {{SlotW{1'b0}}, used_q[IW-1:0]};
	assign walk_ext   = {{SlotW{1'b0}}, walk_q[IW-1:0]};

	// shared per-slot update unit
	csched_slot_unit u_slot_unit (
		.is_dispatch (cmd_q == CMD_DISPATCH),
		.cur         (rd_slot_q),
		.upd         (upd)
	);

	// walk halts while an emitting slot meets a full output register
	assign walk_adv = !(upd.emit && !out_free);

	// table write and read addressing
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = used_q[IW-1:0];
		mem_wdata = new_slot_q;
		mem_raddr = '0;
		unique case (state_q)
			ST_ADD: begin
				mem_we = out_free && !table_full;
			end
			ST_WALK: begin
				mem_waddr = walk_q[IW-1:0];
				mem_wdata = upd.nxt;
				mem_we    = walk_adv && upd.wr_en;
				mem_raddr = walk_adv ? walk_inc[IW-1:0] : walk_q[IW-1:0];
			end
			ST_IDLE, ST_END: begin
				mem_raddr = '0;
			end
			default: begin
				mem_raddr = '0;
			end
		endcase
	end

	// slot table with registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_waddr] <= mem_wdata;
		end
		rd_slot_q <= slot_mem_q[mem_raddr];
	end

	// result selection
	always_comb begin
		out_load     = 1'b0;
		out_kind_d   = KIND_ADD;
		out_acc_d    = 1'b0;
		out_slot_d   = '0;
		out_handle_d = '0;
		out_last_d   = 1'b1;
		unique case (state_q)
			ST_ADD: begin
				out_load   = out_free;
				out_acc_d  = !table_full;
				out_slot_d = table_full ? '0 : used_ext[SlotW-1:0];
			end
			ST_WALK: begin
				out_load     = upd.emit && out_free;
				out_kind_d   = KIND_RUN;
				out_slot_d   = walk_ext[SlotW-1:0];
				out_handle_d = rd_slot_q.handle;
				out_last_d   = 1'b0;
			end
			ST_END: begin
				out_load   = out_free;
				out_kind_d = KIND_END;
			end
			ST_IDLE: begin
				out_load = 1'b0;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// input capture
	always_ff @(posedge clk) begin
		if (in_xact) begin
			new_slot_q.handle  <= s_tdata[15:0];
			new_slot_q.delay   <= s_tdata[47:16];
			new_slot_q.period  <= s_tdata[79:48];
			new_slot_q.pending <= '0;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_TICK;
			used_q  <= '0;
			walk_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xact) begin
						cmd_q  <= cmd_t'(s_tuser);
						walk_q <= '0;
						unique case (cmd_t'(s_tuser))
							CMD_ADD: begin
								state_q <= ST_ADD;
							end
							CMD_CLEAR: begin
								used_q <= '0;
							end
							CMD_TICK: begin
								if (used_q != '0) begin
									state_q <= ST_WALK;
								end
							end
							CMD_DISPATCH: begin
								state_q <= (used_q != '0) ? ST_WALK : ST_END;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ADD: begin
					if (out_free) begin
						if (!table_full) begin
							used_q <= used_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (walk_adv) begin
						walk_q <= walk_inc;
						if (walk_done) begin
							state_q <= (cmd_q == CMD_DISPATCH) ? ST_END : ST_IDLE;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q   <= out_kind_d;
			out_acc_q    <= out_acc_d;
			out_slot_q   <= out_slot_d;
			out_handle_q <= out_handle_d;
			out_last_q   <= out_last_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_handle_q, out_slot_q, out_acc_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

endmodule

### hdl/csched_check.sv
// ---------------------------------------------------------------------------
// csched_check
// Port-level checks for the cooperative task scheduler, bound to the top.
// ---------------------------------------------------------------------------
module csched_check
	import csched_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// end of dispatch closes the command
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_END) |-> m_tlast && (m_tdata[20:0] == '0))
		else $error("end of dispatch malformed");

	// run items never close the command
	a_run_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_RUN) |-> !m_tlast && !m_tdata[0])
		else $error("run item malformed");

	// add response is a single closing item with no handle
	a_add_resp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_ADD) |-> m_tlast && (m_tdata[20:5] == '0))
		else $error("add response malformed");

	// add and dispatch always produce results, so the input side goes busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tuser == CMD_ADD) || (s_tuser == CMD_DISPATCH))
			|=> !s_tready)
		else $error("input ready during add or dispatch");

endmodule

bind cooperative_task_scheduler csched_check u_csched_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

### verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the cooperative task scheduler. A queue of commands
// (directed corner cases, a long tick burst, then random task sets mixed with
// noise) feeds a clocked driver. A shadow copy of the slot table predicts the
// results of every accepted command. A clocked monitor compares each result
// transaction field by field with the oldest prediction. Idle phases vary
// sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module tb;
	import csched_pkg::*;

	localparam int unsigned TABLE_DEPTH = MaxTasksDefault;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 60;
	localparam int unsigned RANDOM_ITEMS_PER_PHASE = 20;
	localparam int unsigned BURST_TICKS = 260;

	// idle phases of the stream handshakes
	typedef enum logic [1:0] {
		IDLE_NONE = 2'd0,
		IDLE_SEND = 2'd1,
		IDLE_RECV = 2'd2,
		IDLE_BOTH = 2'd3
	} idle_mode_t;

	// one command waiting to be sent
	typedef struct {
		cmd_t               cmd;
		logic [HandleW-1:0] handle;
		logic [DelayW-1:0]  delay;
		logic [DelayW-1:0]  period;
		idle_mode_t         mode;
	} sched_cmd_t;

	// one predicted result transaction
	typedef struct {
		kind_t              kind;
		logic               accepted;
		logic [SlotW-1:0]   slot;
		logic [HandleW-1:0] handle;
		logic               last;
	} sched_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;   // task_handle[15:0], first_delay[47:16], repeat_period[79:48]
	logic [1:0]  s_tuser = CMD_TICK;   // cmd[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;   // accepted[0], slot[4:1], run_handle[20:5], zero[23:21]
	logic [1:0]  m_tuser;   // kind[1:0]
	logic        m_tlast;

	// shadow slot table
	logic [HandleW-1:0]  shadow_handle  [TABLE_DEPTH];
	logic [DelayW-1:0]   shadow_delay   [TABLE_DEPTH];
	logic [DelayW-1:0]   shadow_period  [TABLE_DEPTH];
	logic [PendingW-1:0] shadow_pending [TABLE_DEPTH];
	int unsigned         shadow_used = 0;

	sched_cmd_t    cmd_queue[$];
	sched_result_t results_due[$];
	sched_cmd_t    cur_cmd;
	sched_result_t want_res;
	idle_mode_t    idle_mode = IDLE_NONE;
	logic          send_go;
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;

	cooperative_task_scheduler dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// advance the shadow table by one command and queue its results
	function automatic void schedule_command(sched_cmd_t c);
		sched_result_t r;
		int unsigned   i;
		r.accepted = 1'b0;
		r.slot = '0;
		r.handle = '0;
		r.last = 1'b0;
		case (c.cmd)
			CMD_TICK: begin
				for (i = 0; i < shadow_used; i++) begin
					if (shadow_handle[i] != '0) begin
						if (shadow_delay[i] == '0) begin
							if (shadow_pending[i] != 8'hFF)
								shadow_pending[i] = shadow_pending[i] + 8'd1;
							if (shadow_period[i] != '0)
								shadow_delay[i] = shadow_period[i];
						end else begin
							shadow_delay[i] = shadow_delay[i] - 32'd1;
						end
					end
				end
			end
			CMD_ADD: begin
				r.kind = KIND_ADD;
				r.last = 1'b1;
				if (shadow_used < TABLE_DEPTH) begin
					shadow_handle[shadow_used] = c.handle;
					shadow_delay[shadow_used] = c.delay;
					shadow_period[shadow_used] = c.period;
					shadow_pending[shadow_used] = '0;
					r.accepted = 1'b1;
					r.slot = shadow_used[SlotW-1:0];
					shadow_used++;
				end
				results_due.push_back(r);
			end
			CMD_DISPATCH: begin
				r.kind = KIND_RUN;
				for (i = 0; i < shadow_used; i++) begin
					if (shadow_pending[i] != '0) begin
						shadow_pending[i] = shadow_pending[i] - 8'd1;
						r.slot = i[SlotW-1:0];
						r.handle = shadow_handle[i];
						results_due.push_back(r);
						// one-shot tasks leave the table after running
						if (shadow_period[i] == '0) begin
							shadow_handle[i] = '0;
							shadow_delay[i] = '0;
							shadow_period[i] = '0;
							shadow_pending[i] = '0;
						end
					end
				end
				r.kind = KIND_END;
				r.slot = '0;
				r.handle = '0;
				r.last = 1'b1;
				results_due.push_back(r);
			end
			default: begin
				shadow_used = 0;
			end
		endcase
	endfunction

	function automatic void enqueue_command(cmd_t cmd, logic [HandleW-1:0] handle,
			logic [DelayW-1:0] delay, logic [DelayW-1:0] period, idle_mode_t mode);
		sched_cmd_t c;
		c.cmd = cmd;
		c.handle = handle;
		c.delay = delay;
		c.period = period;
		c.mode = mode;
		cmd_queue.push_back(c);
	endfunction

	// mostly short countdowns so tasks come due, sometimes the full range
	function automatic logic [DelayW-1:0] pick_count(int unsigned small_max);
		if ($urandom_range(3) == 0)
			return $urandom;
		return $urandom_range(small_max);
	endfunction

	function automatic logic [HandleW-1:0] pick_handle();
		if ($urandom_range(9) == 0)
			return '0;
		return HandleW'($urandom);
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// driver: hold each command until accepted, predict on acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid)
				schedule_command(cur_cmd);
			send_go = 1'b0;
			if (cmd_queue.size() != 0) begin
				case (cmd_queue[0].mode)
					IDLE_SEND: send_go = ($urandom_range(99) >= 86);
					IDLE_BOTH: send_go = ($urandom_range(99) >= 30);
					default:   send_go = 1'b1;
				endcase
			end
			if (send_go) begin
				cur_cmd = cmd_queue.pop_front();
				idle_mode <= cur_cmd.mode;
				s_tvalid <= 1'b1;
				s_tdata <= {cur_cmd.period, cur_cmd.delay, cur_cmd.handle};
				s_tuser <= cur_cmd.cmd;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor: random back-pressure and result checking
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			case (idle_mode)
				IDLE_RECV: m_tready <= ($urandom_range(99) >= 86);
				IDLE_BOTH: m_tready <= ($urandom_range(99) >= 30);
				default:   m_tready <= 1'b1;
			endcase
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$display("%0t: unexpected result expected none actual tuser %h tdata %h tlast %b",
						$time, m_tuser, m_tdata, m_tlast);
					fail_count++;
				end else begin
					want_res = results_due.pop_front();
					check_field("kind", 32'(want_res.kind), 32'(m_tuser));
					check_field("accepted", 32'(want_res.accepted), 32'(m_tdata[0]));
					check_field("slot", 32'(want_res.slot), 32'(m_tdata[4:1]));
					check_field("run_handle", 32'(want_res.handle), 32'(m_tdata[20:5]));
					check_field("pad", 32'd0, 32'(m_tdata[23:21]));
					check_field("last", 32'(want_res.last), 32'(m_tlast));
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("cooperative_task_scheduler verification failed");
			$finish;
		end
	end

	// stimulus, reset and end of run
	initial begin
		int unsigned n_items;
		int unsigned n_adds;
		int unsigned n_steps;
		int unsigned k;
		idle_mode_t  mode;

		// directed: empty table, one-shot, handle zero, extremes
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_TICK, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'hFFFF, 32'd0, 32'd0, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'h0000, 32'd0, 32'd1, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'h1234, 32'd1, 32'd2, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'h0001, 32'hFFFFFFFF, 32'hFFFFFFFF, IDLE_NONE);
		enqueue_command(CMD_TICK, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_TICK, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);
		// fill the table, then add once more while full
		for (k = 0; k < 13; k++)
			enqueue_command(CMD_ADD, HandleW'($urandom), $urandom_range(2),
				$urandom_range(2), IDLE_NONE);
		enqueue_command(CMD_CLEAR, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'hA5A5, 32'd0, 32'd3, IDLE_NONE);
		enqueue_command(CMD_TICK, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);

		// long tick burst: a due one-shot saturates its pending count
		enqueue_command(CMD_CLEAR, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'h00F0, 32'd0, 32'd0, IDLE_NONE);
		enqueue_command(CMD_ADD, 16'h0F00, 32'd0, 32'd1, IDLE_NONE);
		for (k = 0; k < BURST_TICKS; k++)
			enqueue_command(CMD_TICK, HandleW'($urandom), $urandom, $urandom, IDLE_NONE);
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);

		// random task sets with ticks and dispatches, plus noise, per idle phase
		for (int p = 0; p < 4; p++) begin
			mode = idle_mode_t'(p);
			n_items = 0;
			while (n_items < RANDOM_ITEMS_PER_PHASE) begin
				if ($urandom_range(9) < 7) begin
					if ($urandom_range(3) != 0) begin
						enqueue_command(CMD_CLEAR, HandleW'($urandom), $urandom, $urandom,
							mode);
						n_items++;
					end
					n_adds = $urandom_range(1, 8);
					if ($urandom_range(4) == 0)
						n_adds = $urandom_range(14, 18);
					for (k = 0; k < n_adds; k++)
						enqueue_command(CMD_ADD, pick_handle(), pick_count(4), pick_count(3), mode);
					n_steps = $urandom_range(4, 14);
					for (k = 0; k < n_steps; k++) begin
						if ($urandom_range(9) < 6)
							enqueue_command(CMD_TICK, HandleW'($urandom), $urandom, $urandom,
								mode);
						else
							enqueue_command(CMD_DISPATCH, HandleW'($urandom), $urandom,
								$urandom, mode);
					end
					n_items += n_adds + n_steps;
				end else begin
					n_steps = $urandom_range(1, 5);
					for (k = 0; k < n_steps; k++)
						enqueue_command(cmd_t'($urandom_range(3)), HandleW'($urandom), $urandom,
							$urandom, mode);
					n_items += n_steps;
				end
			end
		end
		enqueue_command(CMD_DISPATCH, '0, '0, '0, IDLE_NONE);

		// reset once at the start
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// wait for all commands to be taken and all results to arrive
		@(posedge clk);
		while (cmd_queue.size() != 0 || s_tvalid || results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("cooperative_task_scheduler verification clean");
		else
			$display("cooperative_task_scheduler verification failed");
		$finish;
	end

endmodule

### sim.f
hdl/csched_pkg.sv
hdl/csched_slot_unit.sv
hdl/cooperative_task_scheduler.sv
hdl/csched_check.sv
verif/tb.sv
